### design/tgad_pkg.sv
// ----------------------------------------------------------------------------
// tgad_pkg
// Types and constants shared by the TGA stream decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR_OK   = 2'd0;
  localparam logic [1:0] KIND_PIXEL    = 2'd1;
  localparam logic [1:0] KIND_BAD_SIG  = 2'd2;
  localparam logic [1:0] KIND_BAD_SIZE = 2'd3;

  // Image type codes found in signature byte 2
  localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
  localparam logic [7:0] IMG_TYPE_RLE = 8'd10;

  // Supported pixel depths
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // RLE packet header: top bit marks a repeated pixel
  localparam logic [7:0] RLE_RUN_FLAG = 8'd128;
  localparam logic [7:0] RLE_RUN_BIAS = 8'd127;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,
    PH_HEADER = 3'b010,
    PH_PIXELS = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic        last_run;
    logic        clamped;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  header_position;
    logic [1:0]  signature_matches;  // bit 0 raw candidate, bit 1 RLE candidate
    logic [15:0] width_store;
    logic [15:0] height_store;
    logic        alpha_mode;
    logic        rle_mode;
    logic [31:0] pixels_left;
    logic [7:0]  packet_left;
    logic        packet_is_run;
    logic [1:0]  colour_byte_index;
    logic [23:0] colour_hold;
  } dec_state_t;

endpackage

`default_nettype wire

### design/tga_image_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_top
// TGA (type 2 raw / type 10 RLE, 24/32 bpp) byte stream decoder with
// valid/ready channels, an input register and an output register.
// ----------------------------------------------------------------------------
// A byte is first held in the input register; its result, if any, is then registered in the output register.
// Throughput: one byte per cycle; the input register drains into the
// decode logic whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears both valid flags and returns the
// decoder to waiting for a file start.
`default_nettype none

module tga_image_stream_decoder_top
  import tgad_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data
);

  in_item_t   in_data_r;
  logic       in_valid_r;
  out_item_t  out_data_r;
  logic       out_valid_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  out_item_t  step_result;
  logic       step_has_result;
  logic       advance;

  // Move the held byte through the decoder when the output slot frees up
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  tgad_step u_step (
    .state_cur  (state_r),
    .item       (in_data_r),
    .state_nxt  (state_nxt),
    .result     (step_result),
    .has_result (step_has_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= PH_WAIT;
      state_r.header_position   <= 5'd0;
      state_r.signature_matches <= 2'b11;
      state_r.width_store       <= 16'd0;
      state_r.height_store      <= 16'd0;
      state_r.alpha_mode        <= 1'b0;
      state_r.rle_mode          <= 1'b0;
      state_r.pixels_left       <= 32'd0;
      state_r.packet_left       <= 8'd0;
      state_r.packet_is_run     <= 1'b0;
      state_r.colour_byte_index <= 2'd0;
      state_r.colour_hold       <= 24'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && step_has_result) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A pixel phase always has pixels still to deliver
  a_pixels_pending : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_PIXELS) |-> (state_r.pixels_left != 32'd0))
    else $error("pixel phase with no pixels left");

  // Only pixel runs can close the image, and they carry at least one pixel
  a_last_is_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_run) |-> (out_data_r.kind == KIND_PIXEL))
    else $error("last_run on a non-pixel result");

  a_run_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind == KIND_PIXEL)) |-> (out_data_r.repeat_res != 8'd0))
    else $error("pixel run with zero repeat count");

  // Header parsing never runs past the descriptor byte
  a_header_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_HEADER) |-> (state_r.header_position <= 5'd17))
    else $error("header position past descriptor");

endmodule

`default_nettype wire

### design/tgad_step.sv
// ----------------------------------------------------------------------------
// tgad_step
// Next-state and result logic for one file byte: header parse, RLE packet
// tracking, pixel assembly and run clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_step
  import tgad_pkg::*;
(
  input  dec_state_t state_cur,
  input  in_item_t   item,
  output dec_state_t state_nxt,
  output out_item_t  result,
  output logic       has_result
);

  // Header byte positions
  localparam logic [4:0] POS_TYPE     = 5'd2;
  localparam logic [4:0] POS_SIG_LAST = 5'd11;
  localparam logic [4:0] POS_WIDTH_LO = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI = 5'd13;
  localparam logic [4:0] POS_HGT_LO   = 5'd14;
  localparam logic [4:0] POS_HGT_HI   = 5'd15;
  localparam logic [4:0] POS_DEPTH    = 5'd16;

  always_comb begin
    dec_state_t st;
    out_item_t  res;
    logic       has;
    logic [4:0] pos;
    logic [7:0] b;
    logic [7:0] want_raw;
    logic [7:0] want_rle;
    logic [7:0] depth;
    logic [7:0] want;
    logic [7:0] rep;
    logic [1:0] last_idx;
    logic       ok;
    logic       over;
    logic       clip;
    logic [31:0] pl_nxt;

    st       = state_cur;
    res      = '0;
    has      = 1'b0;
    b        = item.data_byte;
    pos      = 5'd0;
    want_raw = 8'd0;
    want_rle = 8'd0;
    depth    = 8'd0;
    want     = 8'd0;
    rep      = 8'd0;
    last_idx = 2'd2;
    ok       = 1'b0;
    over     = 1'b0;
    clip     = 1'b0;
    pl_nxt   = 32'd0;

    // Restart on a file start marker, whatever the current phase
    if (item.file_start) begin
      st.phase             = PH_HEADER;
      st.header_position   = 5'd0;
      st.signature_matches = 2'b11;
      st.width_store       = 16'd0;
      st.height_store      = 16'd0;
      st.colour_hold       = 24'd0;
      st.colour_byte_index = 2'd0;
      st.packet_left       = 8'd0;
      st.packet_is_run     = 1'b0;
      st.pixels_left       = 32'd0;
    end

    pos = st.header_position;

    case (st.phase)
      PH_HEADER: begin
        if (pos < POS_WIDTH_LO) begin
          // Signature: only the type byte may be nonzero
          want_raw = (pos == POS_TYPE) ? IMG_TYPE_RAW : 8'd0;
          want_rle = (pos == POS_TYPE) ? IMG_TYPE_RLE : 8'd0;
          if (b != want_raw) st.signature_matches[0] = 1'b0;
          if (b != want_rle) st.signature_matches[1] = 1'b0;
          st.header_position = pos + 5'd1;
          if (pos == POS_SIG_LAST) begin
            if (st.signature_matches == 2'b00) begin
              res.kind = KIND_BAD_SIG;
              has      = 1'b1;
              st.phase = PH_WAIT;
            end else begin
              st.rle_mode = ~st.signature_matches[0];
            end
          end
        end else begin
          st.header_position = pos + 5'd1;
          case (pos)
            POS_WIDTH_LO: st.width_store[7:0]   = b;
            POS_WIDTH_HI: st.width_store[15:8]  = b;
            POS_HGT_LO:   st.height_store[7:0]  = b;
            POS_HGT_HI:   st.height_store[15:8] = b;
            POS_DEPTH:    st.colour_hold        = {16'd0, b};
            default: begin
              // Descriptor byte: check size and depth, report header
              depth = st.colour_hold[7:0];
              ok = ((depth == DEPTH_24) || (depth == DEPTH_32)) &&
                   (st.width_store != 16'd0) && (st.height_store != 16'd0);
              st.alpha_mode        = (depth == DEPTH_32);
              res.image_width      = st.width_store;
              res.image_height     = st.height_store;
              res.has_alpha        = st.alpha_mode;
              st.colour_hold       = 24'd0;
              st.colour_byte_index = 2'd0;
              st.packet_left       = 8'd0;
              st.packet_is_run     = 1'b0;
              has                  = 1'b1;
              if (!ok) begin
                res.kind = KIND_BAD_SIZE;
                st.phase = PH_WAIT;
              end else begin
                res.kind       = KIND_HDR_OK;
                st.pixels_left = {16'd0, st.width_store} * {16'd0, st.height_store};
                st.phase       = PH_PIXELS;
              end
            end
          endcase
        end
      end

      PH_PIXELS: begin
        last_idx = st.alpha_mode ? 2'd3 : 2'd2;
        if (st.rle_mode && (st.packet_left == 8'd0)) begin
          // Packet header byte
          if (b < RLE_RUN_FLAG) begin
            st.packet_left   = b + 8'd1;
            st.packet_is_run = 1'b0;
          end else begin
            st.packet_left   = b - RLE_RUN_BIAS;
            st.packet_is_run = 1'b1;
          end
        end else if (st.colour_byte_index < last_idx) begin
          // Collect colour bytes in file order: B, G, R
          case (st.colour_byte_index)
            2'd0:    st.colour_hold[7:0]   = b;
            2'd1:    st.colour_hold[15:8]  = b;
            2'd2:    st.colour_hold[23:16] = b;
            default: ;
          endcase
          st.colour_byte_index = st.colour_byte_index + 2'd1;
        end else begin
          // Final byte of the pixel: emit the run
          if (st.alpha_mode) begin
            res.red   = st.colour_hold[23:16];
            res.alpha = b;
          end else begin
            res.red   = b;
            res.alpha = 8'd0;
          end
          res.green            = st.colour_hold[15:8];
          res.blue             = st.colour_hold[7:0];
          st.colour_byte_index = 2'd0;

          if (st.rle_mode && st.packet_is_run) begin
            want           = st.packet_left;
            st.packet_left = 8'd0;
            over           = {24'd0, want} > st.pixels_left;
            rep            = over ? st.pixels_left[7:0] : want;
            clip           = over;
          end else begin
            rep = (st.pixels_left != 32'd0) ? 8'd1 : 8'd0;
            if (st.rle_mode) begin
              clip           = (st.pixels_left <= 32'd1) && (st.packet_left > 8'd1);
              st.packet_left = st.packet_left - 8'd1;
            end
          end

          pl_nxt         = st.pixels_left - {24'd0, rep};
          st.pixels_left = pl_nxt;
          res.kind       = KIND_PIXEL;
          res.repeat_res = rep;
          res.last_run   = (pl_nxt == 32'd0);
          res.clamped    = clip;
          has            = 1'b1;
          if (pl_nxt == 32'd0) st.phase = PH_WAIT;
        end
      end

      default: ;
    endcase

    state_nxt  = st;
    result     = res;
    has_result = has;
  end

endmodule

`default_nettype wire
